// ===== sv/setpoint_ramp_q16_core_macros.svh =====
// ----------------------------------------------------------------------------
// Setpoint ramp assertion macros
// Shared concurrent assertion forms for the setpoint ramp core.
// ----------------------------------------------------------------------------
`ifndef SETPOINT_RAMP_Q16_CORE_MACROS_SVH
`define SETPOINT_RAMP_Q16_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRQ16_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("setpoint ramp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRQ16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("setpoint ramp assertion failed");

`endif

// ===== sv/srq16_pkg.sv =====
// ----------------------------------------------------------------------------
// Setpoint ramp package
// Widths, codes, controller states and shared helpers of the ramp core.
// ----------------------------------------------------------------------------
package srq16_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = 48;
    localparam int VEL_W      = 32;
    localparam int LIM_W      = 31;
    localparam int UNIT_W     = 32;
    localparam int DIST_W     = 48;
    localparam int MUL_A_W    = 32;
    localparam int MUL_SPLIT  = 24;
    localparam int PP_W       = MUL_A_W + MUL_SPLIT;
    localparam int PROD_W     = MUL_A_W + DIST_W;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int CNT_W      = $clog2(SQRT_STEPS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VELOCITY     = 2'd0,
        CFG_MAX_ACCELERATION = 2'd1,
        CFG_START_POSITION   = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_SQRT,
        ST_SPEED,
        ST_POS,
        ST_RESTART
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic sqrt_step;
        logic speed_upd;
        logic pos_upd;
        logic restart;
    } dp_cmd_t;

    // Whole units to Q units, sign-extended to the setpoint width.
    function automatic logic signed [POS_W-1:0] q_of_units(input logic signed [UNIT_W-1:0] u);
        logic signed [POS_W-1:0] ext;
        ext = POS_W'(u);
        return ext <<< FRAC_BITS;
    endfunction

endpackage

// ===== sv/srq16_cfg.sv =====
// ----------------------------------------------------------------------------
// Setpoint ramp configuration registers
// Holds the velocity limit, the acceleration limit and the start position.
// ----------------------------------------------------------------------------
module srq16_cfg (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wr_en,
    input  logic [srq16_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [srq16_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic [srq16_pkg::LIM_W-1:0]              max_velocity,
    output logic [srq16_pkg::LIM_W-1:0]              max_acceleration,
    output logic signed [srq16_pkg::UNIT_W-1:0]      start_position
);

    logic [srq16_pkg::LIM_W-1:0]         max_vel_reg;
    logic [srq16_pkg::LIM_W-1:0]         max_acc_reg;
    logic signed [srq16_pkg::UNIT_W-1:0] start_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vel_reg   <= srq16_pkg::LIM_W'(65536);
            max_acc_reg   <= srq16_pkg::LIM_W'(256);
            start_pos_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                srq16_pkg::CFG_MAX_VELOCITY:
                begin
                    max_vel_reg <= cfg_data[srq16_pkg::LIM_W-1:0];
                end
                srq16_pkg::CFG_MAX_ACCELERATION:
                begin
                    max_acc_reg <= cfg_data[srq16_pkg::LIM_W-1:0];
                end
                srq16_pkg::CFG_START_POSITION:
                begin
                    start_pos_reg <= cfg_data[srq16_pkg::UNIT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign max_velocity     = max_vel_reg;
    assign max_acceleration = max_acc_reg;
    assign start_position   = start_pos_reg;

endmodule

// ===== sv/srq16_ctrl.sv =====
// ----------------------------------------------------------------------------
// Setpoint ramp controller
// Sequences the multiply, square root, speed and position steps of an advance
// item, or the restart step, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`include "setpoint_ramp_q16_core_macros.svh"

module srq16_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                action,
    input  logic                out_ready,
    output logic                in_ready,
    output logic                out_valid,
    output srq16_pkg::dp_cmd_t  cmd
);

    srq16_pkg::state_t               state_reg;
    srq16_pkg::state_t               state_next;
    logic [srq16_pkg::CNT_W-1:0]     cnt_reg;
    logic [srq16_pkg::CNT_W-1:0]     cnt_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srq16_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            srq16_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action == srq16_pkg::ACT_RESTART)
                    begin
                        state_next = srq16_pkg::ST_RESTART;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = srq16_pkg::ST_MUL_LO;
                    end
                end
            end
            srq16_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = srq16_pkg::ST_MUL_HI;
            end
            srq16_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = srq16_pkg::ST_SUM;
            end
            srq16_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                cnt_next   = '0;
                state_next = srq16_pkg::ST_SQRT;
            end
            srq16_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == srq16_pkg::CNT_W'(srq16_pkg::SQRT_STEPS - 1))
                begin
                    state_next = srq16_pkg::ST_SPEED;
                end
            end
            srq16_pkg::ST_SPEED:
            begin
                cmd.speed_upd = 1'b1;
                state_next    = srq16_pkg::ST_POS;
            end
            srq16_pkg::ST_POS:
            begin
                if (slot_free)
                begin
                    cmd.pos_upd    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = srq16_pkg::ST_IDLE;
                end
            end
            srq16_pkg::ST_RESTART:
            begin
                if (slot_free)
                begin
                    cmd.restart    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = srq16_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srq16_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `SRQ16_ASSERT_NEXT(a_advance_starts_mul, clk, rst_n, state_reg == srq16_pkg::ST_IDLE && in_valid && action == srq16_pkg::ACT_ADVANCE, state_reg == srq16_pkg::ST_MUL_LO)
    `SRQ16_ASSERT_NEXT(a_sqrt_length, clk, rst_n, state_reg == srq16_pkg::ST_SQRT && cnt_reg == srq16_pkg::CNT_W'(srq16_pkg::SQRT_STEPS - 1), state_reg == srq16_pkg::ST_SPEED)
    `SRQ16_ASSERT_NEXT(a_wait_for_slot, clk, rst_n, (state_reg == srq16_pkg::ST_POS || state_reg == srq16_pkg::ST_RESTART) && out_valid_reg && !out_ready, $stable(state_reg))
    `SRQ16_ASSERT_IMP(a_result_source, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == srq16_pkg::ST_POS || $past(state_reg) == srq16_pkg::ST_RESTART)

endmodule

// ===== sv/srq16_dp.sv =====
// ----------------------------------------------------------------------------
// Setpoint ramp datapath
// Distance, split envelope multiply with saturation, a two-bits-per-cycle
// square root, the acceleration-limited speed update and the position step.
// ----------------------------------------------------------------------------
module srq16_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  srq16_pkg::dp_cmd_t                   cmd,
    input  logic signed [srq16_pkg::UNIT_W-1:0]  target,
    input  logic [srq16_pkg::LIM_W-1:0]          max_velocity,
    input  logic [srq16_pkg::LIM_W-1:0]          max_acceleration,
    input  logic signed [srq16_pkg::UNIT_W-1:0]  start_position,
    output logic signed [srq16_pkg::POS_W-1:0]   position_q16,
    output logic signed [srq16_pkg::UNIT_W-1:0]  position_units,
    output logic signed [srq16_pkg::VEL_W-1:0]   velocity_q16,
    output logic                                 arrived
);

    localparam int POS_W  = srq16_pkg::POS_W;
    localparam int VEL_W  = srq16_pkg::VEL_W;
    localparam int DIST_W = srq16_pkg::DIST_W;
    localparam int PP_W   = srq16_pkg::PP_W;
    localparam int PROD_W = srq16_pkg::PROD_W;
    localparam int RAD_W  = srq16_pkg::RAD_W;
    localparam int ROOT_W = srq16_pkg::ROOT_W;
    localparam int SPLIT  = srq16_pkg::MUL_SPLIT;
    localparam int A_W    = srq16_pkg::MUL_A_W;
    localparam int DIFF_W = VEL_W + 2;

    // Architectural state.
    logic signed [POS_W-1:0] setpoint_reg, setpoint_next;
    logic signed [VEL_W-1:0] speed_reg, speed_next;
    logic                    at_rest_reg, at_rest_next;

    // Per-item working registers.
    logic signed [POS_W-1:0] target_q_reg, target_q_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;
    logic                    neg_reg, neg_next;
    logic [PP_W-1:0]         pp_reg, pp_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [RAD_W-1:0]        rem_reg, rem_next;
    logic [RAD_W-1:0]        root_reg, root_next;
    logic [RAD_W-1:0]        probe_reg, probe_next;

    // Result registers.
    logic signed [POS_W-1:0] out_pos_reg, out_pos_next;
    logic signed [VEL_W-1:0] out_speed_reg, out_speed_next;
    logic                    out_rest_reg, out_rest_next;

    logic signed [POS_W-1:0] target_q;
    logic signed [POS_W:0]   remaining;
    logic [A_W-1:0]          twice_acc;
    logic [PROD_W-1:0]       prod_sum;
    logic [RAD_W-1:0]        trial;
    logic [ROOT_W-1:0]       root_cut;
    logic [ROOT_W-1:0]       vel_lim;
    logic [ROOT_W-1:0]       desired_mag;
    logic signed [DIFF_W-1:0] desired;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] acc_lim;
    logic signed [VEL_W-1:0] acc_step;
    logic [VEL_W-1:0]        step_mag;
    logic signed [POS_W:0]   pos_sum;

    always_comb
    begin
        setpoint_next  = setpoint_reg;
        speed_next     = speed_reg;
        at_rest_next   = at_rest_reg;
        target_q_next  = target_q_reg;
        dist_next      = dist_reg;
        neg_next       = neg_reg;
        pp_next        = pp_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        probe_next     = probe_reg;
        out_pos_next   = out_pos_reg;
        out_speed_next = out_speed_reg;
        out_rest_next  = out_rest_reg;

        target_q  = srq16_pkg::q_of_units(target);
        remaining = (POS_W+1)'(target_q) - (POS_W+1)'(setpoint_reg);
        twice_acc = {max_acceleration, 1'b0};

        prod_sum = prod_reg + (PROD_W'(pp_reg) << SPLIT);
        trial    = root_reg + probe_reg;

        root_cut    = root_reg[ROOT_W-1:0];
        vel_lim     = ROOT_W'(max_velocity);
        desired_mag = (root_cut > vel_lim) ? vel_lim : root_cut;
        desired     = neg_reg ? -$signed(DIFF_W'(desired_mag)) : $signed(DIFF_W'(desired_mag));
        diff        = desired - DIFF_W'(speed_reg);
        acc_lim     = $signed(DIFF_W'(max_acceleration));
        acc_step    = $signed(VEL_W'(max_acceleration));

        step_mag = speed_reg[VEL_W-1] ? VEL_W'(-speed_reg) : VEL_W'(speed_reg);
        pos_sum  = (POS_W+1)'(setpoint_reg) + (POS_W+1)'(speed_reg);

        if (cmd.capture)
        begin
            target_q_next = target_q;
            neg_next      = remaining[POS_W];
            dist_next     = remaining[POS_W] ? DIST_W'(-remaining) : DIST_W'(remaining);
        end

        if (cmd.mul_lo)
        begin
            pp_next = PP_W'(twice_acc) * PP_W'(dist_reg[SPLIT-1:0]);
        end

        if (cmd.mul_hi)
        begin
            prod_next = PROD_W'(pp_reg);
            pp_next   = PP_W'(twice_acc) * PP_W'(dist_reg[DIST_W-1:SPLIT]);
        end

        if (cmd.sum)
        begin
            rem_next   = (|prod_sum[PROD_W-1:RAD_W]) ? '1 : prod_sum[RAD_W-1:0];
            root_next  = '0;
            probe_next = RAD_W'(1) << (RAD_W - 2);
        end

        if (cmd.sqrt_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + probe_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            probe_next = probe_reg >> 2;
        end

        if (cmd.speed_upd)
        begin
            if (diff > acc_lim)
            begin
                speed_next = speed_reg + acc_step;
            end
            else if (diff < -acc_lim)
            begin
                speed_next = speed_reg - acc_step;
            end
            else
            begin
                speed_next = desired[VEL_W-1:0];
            end
        end

        if (cmd.pos_upd)
        begin
            if (DIST_W'(step_mag) >= dist_reg)
            begin
                setpoint_next = target_q_reg;
                speed_next    = '0;
                at_rest_next  = 1'b1;
            end
            else
            begin
                if (pos_sum[POS_W] != pos_sum[POS_W-1])
                begin
                    setpoint_next = pos_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                                   : {1'b0, {(POS_W-1){1'b1}}};
                end
                else
                begin
                    setpoint_next = pos_sum[POS_W-1:0];
                end
                at_rest_next = 1'b0;
            end
        end

        if (cmd.restart)
        begin
            setpoint_next = srq16_pkg::q_of_units(start_position);
            speed_next    = '0;
            at_rest_next  = 1'b1;
        end

        if (cmd.pos_upd || cmd.restart)
        begin
            out_pos_next   = setpoint_next;
            out_speed_next = speed_next;
            out_rest_next  = at_rest_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            speed_reg    <= '0;
            at_rest_reg  <= 1'b1;
        end
        else
        begin
            setpoint_reg <= setpoint_next;
            speed_reg    <= speed_next;
            at_rest_reg  <= at_rest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_q_reg  <= target_q_next;
        dist_reg      <= dist_next;
        neg_reg       <= neg_next;
        pp_reg        <= pp_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        probe_reg     <= probe_next;
        out_pos_reg   <= out_pos_next;
        out_speed_reg <= out_speed_next;
        out_rest_reg  <= out_rest_next;
    end

    assign position_q16   = out_pos_reg;
    assign position_units = srq16_pkg::UNIT_W'(out_pos_reg >>> srq16_pkg::FRAC_BITS);
    assign velocity_q16   = out_speed_reg;
    assign arrived        = out_rest_reg;

endmodule

// ===== sv/setpoint_ramp_q16_core.sv =====
// ----------------------------------------------------------------------------
// Setpoint ramp core, Q16 fixed point
// Trapezoidal setpoint generator: one result beat per input beat.
// ----------------------------------------------------------------------------
// An advance beat runs these steps from acceptance to the next acceptance: it
// forms the distance, does the envelope multiply split into two 32 by 24
// partial products, adds and saturates them, runs the square root that retires
// two radicand bits per cycle, then the speed update and the position step,
// which loads the result register. A restart beat runs only the restart step.
// Items are processed one at a time; a finished result waits in its output
// register while the next item is accepted and worked on, and the position or
// restart step stalls only if that register is still full.
module setpoint_ramp_q16_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [srq16_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srq16_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic signed [srq16_pkg::UNIT_W-1:0]  target,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [srq16_pkg::POS_W-1:0]   position_q16,
    output logic signed [srq16_pkg::UNIT_W-1:0]  position_units,
    output logic signed [srq16_pkg::VEL_W-1:0]   velocity_q16,
    output logic                                 arrived
);

    logic [srq16_pkg::LIM_W-1:0]         max_velocity;
    logic [srq16_pkg::LIM_W-1:0]         max_acceleration;
    logic signed [srq16_pkg::UNIT_W-1:0] start_position;
    srq16_pkg::dp_cmd_t                  cmd;

    srq16_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .max_velocity     (max_velocity),
        .max_acceleration (max_acceleration),
        .start_position   (start_position)
    );

    srq16_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    srq16_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .target           (target),
        .max_velocity     (max_velocity),
        .max_acceleration (max_acceleration),
        .start_position   (start_position),
        .position_q16     (position_q16),
        .position_units   (position_units),
        .velocity_q16     (velocity_q16),
        .arrived          (arrived)
    );

endmodule

// ===== sim/setpoint_ramp_q16_core_test.sv =====
// ----------------------------------------------------------------------------
// Setpoint ramp core testbench
// Drives advance and restart beats with random gaps and output stalls, tracks
// the expected setpoint, speed and arrival in a local profile model, and
// compares every result beat field by field across several limit settings.
// ----------------------------------------------------------------------------
module setpoint_ramp_q16_core_test;

    localparam int     ITEM_GOAL = 1600;
    localparam int     FRAC_BITS = srq16_pkg::FRAC_BITS;
    localparam int     POS_W     = srq16_pkg::POS_W;
    localparam int     UNIT_W    = srq16_pkg::UNIT_W;
    localparam int     VEL_W     = srq16_pkg::VEL_W;
    localparam int     LIM_W     = srq16_pkg::LIM_W;
    localparam int     ROOT_W    = srq16_pkg::ROOT_W;
    localparam int     RAD_W     = srq16_pkg::RAD_W;
    localparam int     CFG_W     = srq16_pkg::CFG_DATA_W;
    localparam longint Q_ONE     = longint'(1) << FRAC_BITS;
    localparam longint POS_HI    = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POS_LO    = -(longint'(1) << (POS_W - 1));
    localparam longint UNIT_HI   = (longint'(1) << (UNIT_W - 1)) - 1;
    localparam longint UNIT_LO   = -(longint'(1) << (UNIT_W - 1));
    localparam logic [LIM_W-1:0] LIM_TOP = '1;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_q;
        logic signed [UNIT_W-1:0] pos_u;
        logic signed [VEL_W-1:0]  vel;
        logic                     at_target;
    } ramp_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 cfg_wr_en;
    logic [srq16_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]                     cfg_data;
    logic                                 in_valid;
    logic                                 in_ready;
    logic                                 action;
    logic signed [UNIT_W-1:0]             target;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [POS_W-1:0]              position_q16;
    logic signed [UNIT_W-1:0]             position_units;
    logic signed [VEL_W-1:0]              velocity_q16;
    logic                                 arrived;

    longint                   mdl_setpoint;
    longint                   mdl_speed;
    bit                       mdl_at_rest;
    longint                   lim_velocity;
    longint                   lim_accel;
    logic signed [UNIT_W-1:0] start_units;

    ramp_result_t pending_results[$];
    bit           idle_on;
    int           stall_left = 0;
    int           errors;
    int           results_checked;
    int           beats_sent;
    int           advances_sent;
    int           restarts_sent;
    int           arrivals_seen;
    int           settings_used;

    setpoint_ramp_q16_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .target         (target),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .position_q16   (position_q16),
        .position_units (position_units),
        .velocity_q16   (velocity_q16),
        .arrived        (arrived)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [RAD_W-1:0] rad);
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (ROOT_W'(1) << b);
            if (RAD_W'(trial) * RAD_W'(trial) <= rad)
                root = trial;
        end
        return root;
    endfunction

    function automatic ramp_result_t ramp_predict(input logic act,
                                                  input logic signed [UNIT_W-1:0] tgt);
        ramp_result_t     r;
        longint           goal;
        longint           rem;
        longint           span;
        longint           want;
        longint           delta;
        longint           vel;
        longint           stride;
        longint           units;
        logic [95:0]      env;
        logic [RAD_W-1:0] rad;
        if (act == srq16_pkg::ACT_RESTART)
        begin
            mdl_setpoint = longint'(start_units) * Q_ONE;
            mdl_speed    = 0;
            mdl_at_rest  = 1'b1;
        end
        else
        begin
            goal = longint'(tgt) * Q_ONE;
            rem  = goal - mdl_setpoint;
            span = (rem < 0) ? -rem : rem;
            env  = 96'(lim_accel) * 96'(span) * 96'(2);
            rad  = (env[95:64] != 0) ? '1 : env[63:0];
            want = longint'(floor_sqrt(rad));
            if (want > lim_velocity)
                want = lim_velocity;
            if (rem < 0)
                want = -want;
            vel   = mdl_speed;
            delta = want - vel;
            if (delta > lim_accel)
                vel = vel + lim_accel;
            else if (delta < -lim_accel)
                vel = vel - lim_accel;
            else
                vel = want;
            stride = (vel < 0) ? -vel : vel;
            if (stride >= span)
            begin
                mdl_setpoint = goal;
                mdl_speed    = 0;
                mdl_at_rest  = 1'b1;
            end
            else
            begin
                mdl_setpoint = mdl_setpoint + vel;
                if (mdl_setpoint > POS_HI)
                    mdl_setpoint = POS_HI;
                if (mdl_setpoint < POS_LO)
                    mdl_setpoint = POS_LO;
                mdl_speed   = vel;
                mdl_at_rest = 1'b0;
            end
        end
        units       = mdl_setpoint >>> FRAC_BITS;
        r.pos_q     = mdl_setpoint[POS_W-1:0];
        r.pos_u     = units[UNIT_W-1:0];
        r.vel       = mdl_speed[VEL_W-1:0];
        r.at_target = mdl_at_rest;
        return r;
    endfunction

    function automatic int pick_gap();
        if (!idle_on || $urandom_range(0, 99) < 55)
            return 0;
        if ($urandom_range(0, 9) < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch at result %0d: %s", results_checked, msg);
    endtask

    task automatic check_result();
        ramp_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result beat with nothing pending");
            return;
        end
        want = pending_results.pop_front();
        if (position_q16 !== want.pos_q)
            report_mismatch($sformatf("position_q16 %0d, expected %0d",
                                      position_q16, want.pos_q));
        if (position_units !== want.pos_u)
            report_mismatch($sformatf("position_units %0d, expected %0d",
                                      position_units, want.pos_u));
        if (velocity_q16 !== want.vel)
            report_mismatch($sformatf("velocity_q16 %0d, expected %0d",
                                      velocity_q16, want.vel));
        if (arrived !== want.at_target)
            report_mismatch($sformatf("arrived %b, expected %b", arrived, want.at_target));
        results_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result();
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (idle_on && $urandom_range(0, 99) < 10)
            begin
                out_ready  <= 1'b0;
                stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                         : $urandom_range(30, 90);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_beat(input logic act, input logic signed [UNIT_W-1:0] tgt);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        target   <= tgt;
        pending_results.push_back(ramp_predict(act, tgt));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        if (act == srq16_pkg::ACT_RESTART)
            restarts_sent++;
        else
        begin
            advances_sent++;
            if (mdl_at_rest)
                arrivals_seen++;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input srq16_pkg::cfg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            srq16_pkg::CFG_MAX_VELOCITY:     lim_velocity = longint'(val[LIM_W-1:0]);
            srq16_pkg::CFG_MAX_ACCELERATION: lim_accel    = longint'(val[LIM_W-1:0]);
            srq16_pkg::CFG_START_POSITION:   start_units  = val;
            default:                         ;
        endcase
    endtask

    task automatic configure(input logic [LIM_W-1:0] vel, input logic [LIM_W-1:0] acc,
                             input logic signed [UNIT_W-1:0] start);
        wait_idle();
        write_reg(srq16_pkg::CFG_MAX_VELOCITY, CFG_W'(vel));
        write_reg(srq16_pkg::CFG_MAX_ACCELERATION, CFG_W'(acc));
        write_reg(srq16_pkg::CFG_START_POSITION, start);
        settings_used++;
    endtask

    function automatic logic signed [UNIT_W-1:0] pick_target();
        longint t;
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        t = (mdl_setpoint >>> FRAC_BITS) + longint'($urandom_range(0, 128)) - 64;
        if (t > UNIT_HI)
            t = UNIT_HI;
        if (t < UNIT_LO)
            t = UNIT_LO;
        return t[UNIT_W-1:0];
    endfunction

    task automatic run_move();
        logic signed [UNIT_W-1:0] dest;
        int                       steps;
        dest  = pick_target();
        steps = 0;
        do
        begin
            send_beat(srq16_pkg::ACT_ADVANCE, dest);
            steps++;
            if ($urandom_range(0, 99) < 2)
                dest = pick_target();
        end
        while (!mdl_at_rest && steps < 150);
        repeat ($urandom_range(0, 2)) send_beat(srq16_pkg::ACT_ADVANCE, dest);
    endtask

    task automatic test_reset_state();
        idle_on = 1'b0;
        send_beat(srq16_pkg::ACT_ADVANCE, 0);
        repeat (3) send_beat(srq16_pkg::ACT_ADVANCE, 1);
        send_beat(srq16_pkg::ACT_RESTART, 0);
    endtask

    task automatic test_extremes();
        idle_on = 1'b0;
        configure(LIM_TOP, LIM_TOP, 32'sh7FFF_FFFF);
        send_beat(srq16_pkg::ACT_RESTART, 0);
        send_beat(srq16_pkg::ACT_ADVANCE, 32'sh8000_0000);
        send_beat(srq16_pkg::ACT_ADVANCE, 32'sh7FFF_FFFF);
        send_beat(srq16_pkg::ACT_ADVANCE, 0);
        send_beat(srq16_pkg::ACT_ADVANCE, 0);
        configure(LIM_TOP, 31'd1, 32'sh8000_0000);
        send_beat(srq16_pkg::ACT_RESTART, 32'sh7FFF_FFFF);
        send_beat(srq16_pkg::ACT_ADVANCE, 32'sh7FFF_FFFF);
        send_beat(srq16_pkg::ACT_ADVANCE, 32'sh8000_0003);
    endtask

    task automatic test_zero_limits();
        idle_on = 1'b0;
        configure(31'd0, 31'd256, 32'sd5);
        send_beat(srq16_pkg::ACT_RESTART, 0);
        send_beat(srq16_pkg::ACT_ADVANCE, 32'sd9);
        send_beat(srq16_pkg::ACT_ADVANCE, 32'sd5);
        configure(31'd65536, 31'd0, 32'sd5);
        send_beat(srq16_pkg::ACT_ADVANCE, 32'sd9);
        send_beat(srq16_pkg::ACT_ADVANCE, -32'sd9);
        send_beat(srq16_pkg::ACT_ADVANCE, 32'sd5);
    endtask

    task automatic test_limit_drop();
        idle_on = 1'b1;
        configure(31'd1 << 20, 31'd1 << 14, 32'sd0);
        send_beat(srq16_pkg::ACT_RESTART, 0);
        repeat (30) send_beat(srq16_pkg::ACT_ADVANCE, 32'sd400);
        wait_idle();
        write_reg(srq16_pkg::CFG_MAX_VELOCITY, 32'd1 << 10);
        write_reg(srq16_pkg::CFG_MAX_ACCELERATION, 32'd1 << 6);
        settings_used++;
        repeat (30) send_beat(srq16_pkg::ACT_ADVANCE, 32'sd400);
    endtask

    task automatic test_random_profiles();
        logic [LIM_W-1:0]         vel;
        logic [LIM_W-1:0]         acc;
        logic signed [UNIT_W-1:0] start;
        int                       phase_end;
        int                       pick;
        while (beats_sent < ITEM_GOAL)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       vel = LIM_TOP;
                1:       vel = LIM_W'($urandom_range(1, 255));
                default: vel = LIM_W'($urandom_range(1 << 12, 1 << 22));
            endcase
            case ($urandom_range(0, 9))
                0:       acc = LIM_TOP;
                1:       acc = LIM_W'($urandom_range(1, 16));
                default: acc = LIM_W'($urandom_range(1 << 8, 1 << 18));
            endcase
            case ($urandom_range(0, 9))
                0:       start = $urandom;
                1:       start = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                default: start = int'($urandom_range(0, 2000)) - 1000;
            endcase
            configure(vel, acc, start);
            send_beat(srq16_pkg::ACT_RESTART, $urandom);
            phase_end = beats_sent + 150;
            while (beats_sent < phase_end && beats_sent < ITEM_GOAL)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    repeat ($urandom_range(1, 8)) send_beat(1'($urandom_range(0, 1)), $urandom);
                else if (pick < 15)
                    send_beat(srq16_pkg::ACT_RESTART, $urandom);
                else
                    run_move();
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = srq16_pkg::CFG_MAX_VELOCITY;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = srq16_pkg::ACT_ADVANCE;
        target       = '0;
        idle_on      = 1'b0;
        lim_velocity = 65536;
        lim_accel    = 256;
        start_units  = '0;
        mdl_setpoint = 0;
        mdl_speed    = 0;
        mdl_at_rest  = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_extremes();
        test_zero_limits();
        test_limit_drop();
        test_random_profiles();
        in_valid <= 1'b0;
        @(posedge clk);
        for (int n = 0; n < 20000 && pending_results.size() != 0; n++)
            @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        repeat (50) @(posedge clk);
        $display("Sent %0d beats (%0d advances, %0d restarts) over %0d limit settings.",
                 beats_sent, advances_sent, restarts_sent, settings_used);
        $display("Checked %0d results, %0d of them arrivals, with %0d mismatches.",
                 results_checked, arrivals_seen, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
